/* rtl/tls_pkg.sv */
// ---------------------------------------------------------------------------
// tls_pkg
// Shared types and codes for the transformer layer scheduler.
// ---------------------------------------------------------------------------
package tls_pkg;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_START   = 4'd1;
    localparam logic [3:0] ST_LAYER   = 4'd2;
    localparam logic [3:0] ST_HEADS   = 4'd3;
    localparam logic [3:0] ST_CONCAT  = 4'd4;
    localparam logic [3:0] ST_OUTPROJ = 4'd5;
    localparam logic [3:0] ST_RES0    = 4'd6;
    localparam logic [3:0] ST_LN0     = 4'd7;
    localparam logic [3:0] ST_FFN     = 4'd8;
    localparam logic [3:0] ST_RES1    = 4'd9;
    localparam logic [3:0] ST_LN1     = 4'd10;
    localparam logic [3:0] ST_LOOP    = 4'd11;
    localparam logic [3:0] ST_STREAM  = 4'd12;

    localparam logic [2:0] PH_QKV     = 3'd0;
    localparam logic [2:0] PH_SCORES  = 3'd1;
    localparam logic [2:0] PH_SOFTMAX = 3'd2;
    localparam logic [2:0] PH_REQ1    = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_REQ2    = 3'd5;
    localparam logic [2:0] PH_KV      = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    localparam logic [3:0] LD_QKV    = 4'd0;
    localparam logic [3:0] LD_CTX_K  = 4'd1;
    localparam logic [3:0] LD_CTX_V  = 4'd2;
    localparam logic [3:0] LD_K_WR   = 4'd3;
    localparam logic [3:0] LD_V_WR   = 4'd4;
    localparam logic [3:0] LD_WO     = 4'd5;
    localparam logic [3:0] LD_W1     = 4'd6;
    localparam logic [3:0] LD_W2     = 4'd7;
    localparam logic [3:0] LD_LOGITS = 4'd8;

    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_QKV     = 5'd1;
    localparam logic [4:0] OP_SCORES  = 5'd2;
    localparam logic [4:0] OP_SOFTMAX = 5'd3;
    localparam logic [4:0] OP_REQUANT = 5'd4;
    localparam logic [4:0] OP_VALUE   = 5'd5;
    localparam logic [4:0] OP_CONCAT  = 5'd6;
    localparam logic [4:0] OP_OUTPROJ = 5'd7;
    localparam logic [4:0] OP_RESID0  = 5'd8;
    localparam logic [4:0] OP_LN0     = 5'd9;
    localparam logic [4:0] OP_W1      = 5'd10;
    localparam logic [4:0] OP_ACT     = 5'd11;
    localparam logic [4:0] OP_W2      = 5'd12;
    localparam logic [4:0] OP_RESID1  = 5'd13;
    localparam logic [4:0] OP_LN1     = 5'd14;
    localparam logic [4:0] OP_DEQUANT = 5'd15;
    localparam logic [4:0] OP_LOGITS  = 5'd16;

    localparam logic [2:0] CFG_LAYERS  = 3'd0;
    localparam logic [2:0] CFG_OUTPROJ = 3'd1;
    localparam logic [2:0] CFG_FFN1    = 3'd2;
    localparam logic [2:0] CFG_FFN2    = 3'd3;
    localparam logic [2:0] CFG_LOGITS  = 3'd4;

    localparam int WF_DMA  = 0;
    localparam int WF_COMP = 1;
    localparam int WF_RES0 = 2;
    localparam int WF_LN0  = 3;
    localparam int WF_RES1 = 4;
    localparam int WF_LN1  = 5;
    localparam int WF_ACT  = 6;
    localparam int WF_DEQ  = 7;
    localparam int WF_EGR  = 8;
    localparam int WF_CAT  = 9;

    typedef struct packed {
        logic       valid;
        logic [5:0] stamp;
        logic [2:0] phase;
        logic       dma_pend;
        logic       comp_pend;
        logic       dma_flag;
        logic       comp_flag;
    } head_ctx_t;

    typedef struct packed {
        logic start_req;
        logic soft_reset;
        logic in_valid;
        logic in_last;
        logic loader_ready;
        logic dma_finished;
        logic engine_ready;
        logic engine_finished;
        logic egress_ready;
        logic egress_finished;
    } in_word_t;

    typedef struct packed {
        logic       all_done;
        logic       egress_start;
        logic [4:0] op_code;
        logic       op_start;
        logic [7:0] load_tile;
        logic [6:0] load_head;
        logic [5:0] load_layer;
        logic [3:0] load_select;
        logic       load_start;
        logic       in_ready;
        logic [5:0] current_layer;
    } out_word_t;

    typedef struct packed {
        logic [6:0] layer_count;
        logic [7:0] out_proj_tiles;
        logic [7:0] ffn_first_tiles;
        logic [7:0] ffn_second_tiles;
        logic [7:0] logit_tiles;
    } cfg_t;

endpackage

/* rtl/tls_cfg.sv */
// ---------------------------------------------------------------------------
// tls_cfg
// Configuration register file: layer count and tile counts.
// ---------------------------------------------------------------------------
module tls_cfg
    import tls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{7'd4, 8'd4, 8'd4, 8'd4, 8'd4};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LAYERS:  cfg_reg.layer_count      <= cfg_data[6:0];
                CFG_OUTPROJ: cfg_reg.out_proj_tiles   <= cfg_data;
                CFG_FFN1:    cfg_reg.ffn_first_tiles  <= cfg_data;
                CFG_FFN2:    cfg_reg.ffn_second_tiles <= cfg_data;
                CFG_LOGITS:  cfg_reg.logit_tiles      <= cfg_data;
                default:     ;
            endcase
        end
    end

endmodule

/* rtl/tls_core.sv */
// ---------------------------------------------------------------------------
// tls_core
// Sequencer: one registered input word in, one result word computed.
// ---------------------------------------------------------------------------
module tls_core
    import tls_pkg::*;
#(
    parameter int HEAD_COUNT      = 8,
    parameter int LANES_PER_GROUP = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  in_w,
    input  cfg_t      cfg,
    output out_word_t res
);

    localparam int GROUP_COUNT = (HEAD_COUNT + LANES_PER_GROUP - 1) / LANES_PER_GROUP;
    localparam int HW = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  layer_reg, layer_next;
    logic [5:0]  group_reg, group_next;
    logic        rearm_reg, rearm_next;
    logic        embw_reg, embw_next;
    logic [7:0]  tile_reg, tile_next;
    logic [1:0]  sub_reg, sub_next;
    logic [11:0] wf_reg, wf_next;
    head_ctx_t   ctx_reg [HEAD_COUNT];
    head_ctx_t   ctx_next [HEAD_COUNT];
    logic        dbusy_reg, dbusy_next, cbusy_reg, cbusy_next;
    logic [5:0]  downer_reg, downer_next, cowner_reg, cowner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            layer_reg  <= '0;
            group_reg  <= '0;
            rearm_reg  <= 1'b1;
            embw_reg   <= 1'b0;
            tile_reg   <= '0;
            sub_reg    <= '0;
            wf_reg     <= '0;
            dbusy_reg  <= 1'b0;
            cbusy_reg  <= 1'b0;
            downer_reg <= '0;
            cowner_reg <= '0;
            for (int i = 0; i < HEAD_COUNT; i++)
            begin
                ctx_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            state_reg  <= state_next;
            layer_reg  <= layer_next;
            group_reg  <= group_next;
            rearm_reg  <= rearm_next;
            embw_reg   <= embw_next;
            tile_reg   <= tile_next;
            sub_reg    <= sub_next;
            wf_reg     <= wf_next;
            dbusy_reg  <= dbusy_next;
            cbusy_reg  <= cbusy_next;
            downer_reg <= downer_next;
            cowner_reg <= cowner_next;
            for (int i = 0; i < HEAD_COUNT; i++)
            begin
                ctx_reg[i] <= ctx_next[i];
            end
        end
    end

    always_comb
    begin
        logic [6:0] layers;
        logic       fin;
        logic       lr, dd, cr, cd;
        logic [6:0] hidx;
        logic [HW-1:0] hs;
        logic       tdone;
        head_ctx_t  c;

        state_next  = state_reg;
        layer_next  = layer_reg;
        group_next  = group_reg;
        rearm_next  = rearm_reg;
        embw_next   = embw_reg;
        tile_next   = tile_reg;
        sub_next    = sub_reg;
        wf_next     = wf_reg;
        dbusy_next  = dbusy_reg;
        cbusy_next  = cbusy_reg;
        downer_next = downer_reg;
        cowner_next = cowner_reg;
        for (int i = 0; i < HEAD_COUNT; i++)
        begin
            ctx_next[i] = ctx_reg[i];
        end
        fin   = 1'b1;
        hidx  = '0;
        hs    = '0;
        tdone = 1'b0;
        c     = '0;
        lr = in_w.loader_ready;
        dd = in_w.dma_finished;
        cr = in_w.engine_ready;
        cd = in_w.engine_finished;
        layers = (cfg.layer_count > 7'd64) ? 7'd64 : cfg.layer_count;

        res = '0;
        res.current_layer = layer_reg;
        res.load_layer = layer_reg;

        if (in_w.soft_reset)
        begin
            state_next = ST_IDLE; layer_next = '0; group_next = '0; rearm_next = 1'b1;
            embw_next = 1'b0; tile_next = '0; sub_next = '0; wf_next = '0;
            dbusy_next = 1'b0; cbusy_next = 1'b0; downer_next = '0; cowner_next = '0;
            for (int i = 0; i < HEAD_COUNT; i++)
            begin
                ctx_next[i] = '0;
            end
            res.load_layer = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_w.start_req)
                    begin
                        state_next = ST_START; layer_next = '0; group_next = '0;
                        rearm_next = 1'b1; embw_next = 1'b0; sub_next = '0;
                        for (int i = 0; i < HEAD_COUNT; i++)
                        begin
                            ctx_next[i] = '0;
                        end
                    end
                end
                ST_START:
                begin
                    res.in_ready = 1'b1;
                    if (in_w.start_req || embw_reg)
                    begin
                        embw_next = 1'b1;
                        if (in_w.in_valid && in_w.in_last)
                        begin
                            embw_next = 1'b0;
                            state_next = ST_LAYER;
                        end
                    end
                end
                ST_LAYER:
                begin
                    group_next = '0; rearm_next = 1'b1; state_next = ST_HEADS;
                end
                ST_HEADS:
                begin
                    if (rearm_reg)
                    begin
                        dbusy_next = 1'b0; cbusy_next = 1'b0;
                        downer_next = '0; cowner_next = '0;
                    end
                    if (dd && dbusy_next)
                    begin
                        for (int i = 0; i < HEAD_COUNT; i++)
                        begin
                            if (downer_next == 6'(i))
                            begin
                                ctx_next[i].dma_flag = 1'b1;
                            end
                        end
                        dbusy_next = 1'b0;
                    end
                    if (cd && cbusy_next)
                    begin
                        for (int i = 0; i < HEAD_COUNT; i++)
                        begin
                            if (cowner_next == 6'(i))
                            begin
                                ctx_next[i].comp_flag = 1'b1;
                            end
                        end
                        cbusy_next = 1'b0;
                    end
                    for (int ln = 0; ln < LANES_PER_GROUP; ln++)
                    begin
                        hidx = 7'(group_reg) * 7'(LANES_PER_GROUP) + 7'(ln);
                        if (hidx < 7'(HEAD_COUNT))
                        begin
                            hs = hidx[HW-1:0];
                            c = ctx_next[hs];
                            if (!c.valid || c.stamp != layer_reg)
                            begin
                                c = '0; c.valid = 1'b1; c.stamp = layer_reg;
                            end
                            if (c.phase != PH_DONE)
                            begin
                                fin = 1'b0;
                                case (c.phase)
                                    PH_QKV, PH_SCORES, PH_VALUE:
                                    begin
                                        if (!c.dma_pend)
                                        begin
                                            if (!dbusy_next && lr && !res.load_start)
                                            begin
                                                res.load_start = 1'b1;
                                                res.load_select =
                                                    (c.phase == PH_QKV) ? LD_QKV :
                                                    (c.phase == PH_SCORES) ? LD_CTX_K
                                                                           : LD_CTX_V;
                                                res.load_head = hidx;
                                                dbusy_next = 1'b1; downer_next = hidx[5:0];
                                                c.dma_pend = 1'b1;
                                            end
                                        end
                                        else if (c.dma_flag)
                                        begin
                                            c.dma_flag = 1'b0; c.dma_pend = 1'b0;
                                            c.comp_pend = 1'b1;
                                        end
                                        if (c.comp_pend && !c.comp_flag)
                                        begin
                                            if (!cbusy_next && cr && !res.op_start)
                                            begin
                                                res.op_start = 1'b1;
                                                res.op_code =
                                                    (c.phase == PH_QKV) ? OP_QKV :
                                                    (c.phase == PH_SCORES) ? OP_SCORES
                                                                           : OP_VALUE;
                                                cbusy_next = 1'b1; cowner_next = hidx[5:0];
                                            end
                                        end
                                        else if (c.comp_flag)
                                        begin
                                            c.comp_flag = 1'b0; c.comp_pend = 1'b0;
                                            c.phase = c.phase + 3'd1;
                                        end
                                    end
                                    PH_SOFTMAX, PH_REQ1, PH_REQ2:
                                    begin
                                        if (!c.comp_pend)
                                        begin
                                            if (!cbusy_next && cr && !res.op_start)
                                            begin
                                                res.op_start = 1'b1;
                                                res.op_code = (c.phase == PH_SOFTMAX)
                                                              ? OP_SOFTMAX : OP_REQUANT;
                                                cbusy_next = 1'b1; cowner_next = hidx[5:0];
                                                c.comp_pend = 1'b1;
                                            end
                                        end
                                        else if (c.comp_flag)
                                        begin
                                            c.comp_flag = 1'b0; c.comp_pend = 1'b0;
                                            c.phase = c.phase + 3'd1;
                                        end
                                    end
                                    PH_KV:
                                    begin
                                        if (!c.dma_pend && !c.comp_pend)
                                        begin
                                            if (!dbusy_next && lr && !res.load_start)
                                            begin
                                                res.load_start = 1'b1;
                                                res.load_select = LD_K_WR;
                                                res.load_head = hidx;
                                                dbusy_next = 1'b1; downer_next = hidx[5:0];
                                                c.dma_pend = 1'b1;
                                            end
                                        end
                                        else if (c.dma_pend && c.dma_flag)
                                        begin
                                            c.dma_flag = 1'b0; c.dma_pend = 1'b0;
                                            if (!c.comp_pend)
                                            begin
                                                c.comp_pend = 1'b1;
                                            end
                                            else
                                            begin
                                                c.comp_pend = 1'b0; c.phase = PH_DONE;
                                            end
                                        end
                                        if (c.comp_pend && !c.dma_pend)
                                        begin
                                            if (!dbusy_next && lr && !res.load_start)
                                            begin
                                                res.load_start = 1'b1;
                                                res.load_select = LD_V_WR;
                                                res.load_head = hidx;
                                                dbusy_next = 1'b1; downer_next = hidx[5:0];
                                                c.dma_pend = 1'b1;
                                            end
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            ctx_next[hs] = c;
                        end
                    end
                    if (fin && !dbusy_next && !cbusy_next)
                    begin
                        rearm_next = 1'b1;
                        if (7'(group_reg) + 7'd1 >= 7'(GROUP_COUNT))
                        begin
                            state_next = ST_CONCAT;
                        end
                        group_next = group_reg + 6'd1;
                    end
                    else
                    begin
                        rearm_next = 1'b0;
                    end
                end
                ST_CONCAT:
                begin
                    if (!wf_reg[WF_CAT] && cr)
                    begin
                        res.op_start = 1'b1; res.op_code = OP_CONCAT; wf_next[WF_CAT] = 1'b1;
                    end
                    else if (wf_reg[WF_CAT] && cd)
                    begin
                        wf_next[WF_CAT] = 1'b0; wf_next[WF_DMA] = 1'b0;
                        wf_next[WF_COMP] = 1'b0;
                        state_next = ST_OUTPROJ; tile_next = '0;
                    end
                end
                ST_OUTPROJ, ST_STREAM, ST_FFN:
                begin
                    if (state_reg == ST_FFN && sub_reg == 2'd3)
                    begin
                        state_next = ST_RES1;
                    end
                    else if (state_reg == ST_FFN && sub_reg == 2'd1)
                    begin
                        if (!wf_reg[WF_ACT] && cr)
                        begin
                            res.op_start = 1'b1; res.op_code = OP_ACT; wf_next[WF_ACT] = 1'b1;
                        end
                        else if (wf_reg[WF_ACT] && cd)
                        begin
                            wf_next[WF_ACT] = 1'b0; sub_next = 2'd2; tile_next = '0;
                        end
                    end
                    else if (state_reg == ST_FFN)
                    begin
                        if (wf_reg[WF_DMA] && dd)
                        begin
                            wf_next[WF_DMA] = 1'b0; wf_next[WF_COMP] = 1'b1;
                        end
                        if (tile_reg >= ((sub_reg == 2'd0) ? cfg.ffn_first_tiles
                                                             : cfg.ffn_second_tiles))
                        begin
                            if (!wf_next[WF_DMA] && !wf_next[WF_COMP])
                            begin
                                tdone = 1'b1;
                            end
                        end
                        else if (!wf_next[WF_DMA] && lr)
                        begin
                            res.load_start = 1'b1;
                            res.load_select = (sub_reg == 2'd0) ? LD_W1 : LD_W2;
                            res.load_head = 7'h7F; res.load_tile = tile_reg;
                            wf_next[WF_DMA] = 1'b1;
                        end
                        if (wf_next[WF_COMP] && cr)
                        begin
                            res.op_start = 1'b1;
                            res.op_code = (sub_reg == 2'd0) ? OP_W1 : OP_W2;
                            wf_next[WF_COMP] = 1'b0; tile_next = tile_reg + 8'd1;
                        end
                        if (tdone)
                        begin
                            if (sub_reg == 2'd0)
                            begin
                                sub_next = 2'd1; wf_next[WF_ACT] = 1'b0;
                            end
                            else
                            begin
                                sub_next = 2'd3;
                            end
                        end
                    end
                    else if (state_reg == ST_STREAM && sub_reg == 2'd0)
                    begin
                        if (!wf_reg[WF_DEQ] && cr)
                        begin
                            res.op_start = 1'b1; res.op_code = OP_DEQUANT;
                            wf_next[WF_DEQ] = 1'b1;
                        end
                        else if (wf_reg[WF_DEQ] && cd)
                        begin
                            wf_next[WF_DEQ] = 1'b0; sub_next = 2'd1;
                        end
                    end
                    else if (state_reg == ST_STREAM && sub_reg == 2'd2)
                    begin
                        if (!wf_reg[WF_EGR] && in_w.egress_ready)
                        begin
                            res.egress_start = 1'b1; wf_next[WF_EGR] = 1'b1;
                        end
                        else if (wf_reg[WF_EGR] && in_w.egress_finished)
                        begin
                            wf_next[WF_EGR] = 1'b0; sub_next = 2'd3;
                        end
                    end
                    else if (state_reg == ST_STREAM && sub_reg == 2'd3)
                    begin
                        res.all_done = 1'b1;
                        if (!in_w.start_req)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // out projection or logits tiles: advance on issue
                        if (tile_reg >= ((state_reg == ST_OUTPROJ) ? cfg.out_proj_tiles
                                                                   : cfg.logit_tiles))
                        begin
                            if (state_reg == ST_OUTPROJ)
                            begin
                                state_next = ST_RES0;
                            end
                            else
                            begin
                                sub_next = 2'd2;
                            end
                            tdone = 1'b1;
                        end
                        else if (!wf_reg[WF_DMA] && lr)
                        begin
                            res.load_start = 1'b1;
                            res.load_select = (state_reg == ST_OUTPROJ) ? LD_WO : LD_LOGITS;
                            res.load_head = 7'h7F; res.load_tile = tile_reg;
                            wf_next[WF_DMA] = 1'b1;
                        end
                        else if (wf_reg[WF_DMA] && dd)
                        begin
                            wf_next[WF_DMA] = 1'b0; wf_next[WF_COMP] = 1'b1;
                        end
                        if ((state_reg == ST_STREAM || !tdone) && wf_next[WF_COMP] && cr)
                        begin
                            res.op_start = 1'b1;
                            res.op_code = (state_reg == ST_OUTPROJ) ? OP_OUTPROJ : OP_LOGITS;
                            wf_next[WF_COMP] = 1'b0; tile_next = tile_reg + 8'd1;
                        end
                    end
                end
                ST_RES0, ST_LN0, ST_RES1, ST_LN1:
                begin
                    hidx = '0;
                    if (state_reg == ST_RES0) hidx[3:0] = 4'(WF_RES0);
                    else if (state_reg == ST_LN0) hidx[3:0] = 4'(WF_LN0);
                    else if (state_reg == ST_RES1) hidx[3:0] = 4'(WF_RES1);
                    else hidx[3:0] = 4'(WF_LN1);
                    if (!wf_reg[hidx[3:0]] && cr)
                    begin
                        res.op_start = 1'b1;
                        res.op_code = (state_reg == ST_RES0) ? OP_RESID0 :
                                      (state_reg == ST_LN0)  ? OP_LN0 :
                                      (state_reg == ST_RES1) ? OP_RESID1 : OP_LN1;
                        wf_next[hidx[3:0]] = 1'b1;
                    end
                    else if (wf_reg[hidx[3:0]] && cd)
                    begin
                        wf_next[hidx[3:0]] = 1'b0;
                        state_next = state_reg + 4'd1;
                        if (state_reg == ST_LN0)
                        begin
                            sub_next = '0; tile_next = '0;
                            wf_next[WF_DMA] = 1'b0; wf_next[WF_COMP] = 1'b0;
                            wf_next[WF_ACT] = 1'b0;
                        end
                    end
                end
                ST_LOOP:
                begin
                    if (7'(layer_reg) + 7'd1 < layers)
                    begin
                        layer_next = layer_reg + 6'd1; state_next = ST_LAYER;
                    end
                    else
                    begin
                        state_next = ST_STREAM; sub_next = '0; tile_next = '0;
                        wf_next[WF_DMA] = 1'b0; wf_next[WF_COMP] = 1'b0;
                        wf_next[WF_DEQ] = 1'b0; wf_next[WF_EGR] = 1'b0;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/transformer_layer_scheduler.sv */
// ---------------------------------------------------------------------------
// transformer_layer_scheduler
// Sequencer for transformer inference driven by handshake sample words.
// ---------------------------------------------------------------------------
// Each input word is one cycle's handshake sample; it is registered, the
// sequencer computes the answer word from it in one pass and the answer sits
// in an output register. One word is taken every cycle unless the skid stage
// holds a word; the output register with a one-entry skid stage keeps the
// input and output sides decoupled.
module transformer_layer_scheduler
    import tls_pkg::*;
#(
    parameter int HEAD_COUNT      = 8,
    parameter int LANES_PER_GROUP = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // start_req, soft_reset, in_valid, in_last, loader_ready,
                                  // dma_finished, engine_ready, engine_finished,
                                  // egress_ready, egress_finished, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // current_layer, in_ready, load_start, load_select,
                                  // load_layer, load_head, load_tile, op_start, op_code,
                                  // egress_start, all_done, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t      cfg;
    in_word_t  in_reg;
    logic      in_vld_reg;
    out_word_t res;
    out_word_t out_reg, skid_reg;
    logic      out_vld_reg, skid_vld_reg;
    logic      step;

    tls_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage advances when an input word is held and the skid slot is free
    assign step = in_vld_reg && !skid_vld_reg;
    assign s_tready = !skid_vld_reg;

    tls_core #(.HEAD_COUNT(HEAD_COUNT), .LANES_PER_GROUP(LANES_PER_GROUP)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .in_w  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (step)
            begin
                if (out_vld_reg && !m_tready)
                begin
                    skid_vld_reg <= 1'b1;
                end
                else
                begin
                    out_vld_reg <= 1'b1;
                end
            end
            else if (m_tready || !out_vld_reg)
            begin
                out_vld_reg  <= skid_vld_reg;
                skid_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= {s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3], s_tdata[4],
                       s_tdata[5], s_tdata[6], s_tdata[7], s_tdata[8], s_tdata[9]};
        end
        if (step)
        begin
            if (out_vld_reg && !m_tready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (m_tready || !out_vld_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_reg};

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word without output word");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !skid_vld_reg) |=> m_tvalid)
        else $error("output word dropped");
    a_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[40]) |-> !m_tdata[6])
        else $error("all_done with in_ready");

endmodule
